// ----- rtl/kea_pkg.sv -----
// shared constants and tables for the kepler eccentric anomaly solver
`timescale 1ns / 1ps
package kea_pkg;

  // pi in Q3.61, source of the angle-format pi
  localparam logic [63:0] PI_Q61          = 64'h6487ED5110B4611A;
  localparam longint      PI_Q30          = 64'd3373259426;
  localparam longint      HALF_PI_Q30     = 64'd1686629713;
  localparam longint      CORDIC_GAIN_Q30 = 64'd652032874;
  localparam longint      ONE_Q30         = 64'd1073741824;
  localparam int          CORDIC_STEPS    = 30;
  localparam logic [15:0] ECC_START_LIMIT = 16'd52429;

  // cordic working widths, q.30
  localparam int CXW = 34;
  localparam int CAW = 36;

  // configuration register indexes
  localparam logic CFG_ITER_LIMIT = 1'b0;
  localparam logic CFG_TOLERANCE  = 1'b1;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      default: v = (idx < 5'd30) ? (30'd1 << (5'd30 - idx)) : 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/kea_cordic.sv -----
// iterative rotation-mode cordic giving sine and cosine of an angle
`timescale 1ns / 1ps
module kea_cordic #(
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output logic                          done,
  output logic signed [ANGLE_WIDTH-1:0] sin_out,
  output logic signed [ANGLE_WIDTH-1:0] cos_out
);
  import kea_pkg::*;

  localparam int F    = ANGLE_WIDTH - 4;
  localparam int SH_R = (F >= 30) ? F - 30 : 0;
  localparam int SH_L = (F < 30) ? 30 - F : 0;

  localparam logic signed [CAW-1:0] PI_C      = CAW'(PI_Q30);
  localparam logic signed [CAW-1:0] TWO_PI_C  = CAW'(2 * PI_Q30);
  localparam logic signed [CAW-1:0] HALF_PI_C = CAW'(HALF_PI_Q30);
  localparam logic signed [CXW-1:0] ONE_C     = CXW'(ONE_Q30);

  typedef enum logic [2:0] {C_IDLE, C_FOLD, C_HALF, C_ROT, C_OUT} cst_t;

  cst_t                   st_r;
  logic signed [CAW-1:0]  a_r;
  logic signed [CXW-1:0]  x_r, y_r;
  logic [4:0]             i_r;
  logic                   neg_r;
  logic                   done_r;
  logic signed [ANGLE_WIDTH-1:0] sin_r, cos_r;

  logic signed [63:0]     ang64, sx64, cx64;
  logic signed [CAW-1:0]  a_in;
  logic signed [CAW-1:0]  at;
  logic signed [CXW-1:0]  xs, ys, xc, yc;

  always_comb begin
    ang64 = 64'(angle);
    a_in  = CAW'((ang64 >>> SH_R) <<< SH_L);
    at    = CAW'({1'b0, atan_q30(i_r)});
    xs    = x_r >>> i_r;
    ys    = y_r >>> i_r;
    // clamp to unit range, negate cos when folded
    if (x_r > ONE_C) xc = ONE_C;
    else if (x_r < -ONE_C) xc = -ONE_C;
    else xc = x_r;
    if (y_r > ONE_C) yc = ONE_C;
    else if (y_r < -ONE_C) yc = -ONE_C;
    else yc = y_r;
    if (neg_r) xc = -xc;
    sx64 = (64'(yc) <<< SH_R) >>> SH_L;
    cx64 = (64'(xc) <<< SH_R) >>> SH_L;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == C_OUT);
      unique case (st_r)
        C_IDLE: begin
          if (start) begin
            a_r  <= a_in;
            st_r <= C_FOLD;
          end
        end
        C_FOLD: begin
          if (a_r > PI_C) a_r <= a_r - TWO_PI_C;
          else if (a_r < -PI_C) a_r <= a_r + TWO_PI_C;
          else st_r <= C_HALF;
        end
        C_HALF: begin
          neg_r <= (a_r > HALF_PI_C) || (a_r < -HALF_PI_C);
          if (a_r > HALF_PI_C) begin
            a_r <= PI_C - a_r;
          end else if (a_r < -HALF_PI_C) begin
            a_r <= -PI_C - a_r;
          end
          x_r  <= CXW'(CORDIC_GAIN_Q30);
          y_r  <= '0;
          i_r  <= '0;
          st_r <= C_ROT;
        end
        C_ROT: begin
          if (a_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            a_r <= a_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            a_r <= a_r + at;
          end
          i_r <= i_r + 5'd1;
          if (i_r == 5'(CORDIC_STEPS - 1)) st_r <= C_OUT;
        end
        C_OUT: begin
          sin_r  <= ANGLE_WIDTH'(sx64);
          cos_r  <= ANGLE_WIDTH'(cx64);
          st_r   <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign sin_out = sin_r;
  assign cos_out = cos_r;

endmodule

// ----- rtl/kea_div.sv -----
// restoring bit-serial divider for the newton step, saturating at 32
`timescale 1ns / 1ps
module kea_div #(
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ANGLE_WIDTH+1:0]   num,
  input  logic [ANGLE_WIDTH-3:0]   den,
  output logic                     done,
  output logic [ANGLE_WIDTH+1:0]   quot
);
  localparam int F     = ANGLE_WIDTH - 4;
  localparam int NW    = ANGLE_WIDTH + 2;
  localparam int RW    = F + 2;
  localparam int QW    = F + 5;
  localparam int STEPS = NW + F;
  localparam int CNTW  = $clog2(STEPS + 1);

  logic            busy_r, done_r, big_r;
  logic [NW-1:0]   nsh_r;
  logic [RW-1:0]   r_r, d_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   quot_r;

  logic [RW:0]     rs;
  logic            fit;

  always_comb begin
    rs  = {r_r, nsh_r[NW-1]};
    fit = rs >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNTW'(STEPS - 1));
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        nsh_r  <= num;
        d_r    <= den;
        r_r    <= '0;
        q_r    <= '0;
        big_r  <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        nsh_r <= {nsh_r[NW-2:0], 1'b0};
        r_r   <= fit ? RW'(rs - {1'b0, d_r}) : RW'(rs);
        q_r   <= {q_r[QW-2:0], fit};
        big_r <= big_r | q_r[QW-1];
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
      if (done_r) begin
        // integer part of 32 or more saturates the step
        quot_r <= big_r ? (NW'(1) << (F + 5)) : NW'(q_r);
      end
    end
  end

  // result is registered in the cycle after internal done; done is delayed to match
  logic done_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done_d_r <= 1'b0;
    else        done_d_r <= done_r;
  end

  assign done = done_d_r;
  assign quot = quot_r;

endmodule

// ----- rtl/kepler_eccentric_anomaly.sv -----
// top level: newton solver for the kepler equation E - e*sin(E) = M
//
// usage
//   input channel in_valid/in_ready carries mean anomaly (signed q4.F, F =
//   ANGLE_WIDTH-4) and eccentricity (unsigned q0.16). one transfer gives
//   exactly one result on out_valid/out_ready: eccentric anomaly, number of
//   newton updates and a converged flag.
//   config channel cfg_valid/cfg_ready (always ready) writes iteration_limit
//   (index 0) and tolerance (index 1); write only while idle.
// flow
//   one item at a time. M is first reduced into range, then each newton
//   update runs the shared cordic (fold plus 30 rotations), the shared
//   multiplier and the serial divider, plus sequencer states; up to 15
//   updates per item. at ANGLE_WIDTH 32 the divider is the longest part.
// reset
//   rst_n synchronous active low; clears the sequencer, output valid and sets
//   iteration_limit to 15, tolerance to 64.
// stalls
//   the result sits in an output register; a new item is taken while it waits,
//   and the solver holds its finished result until the output register frees.
`timescale 1ns / 1ps
module kepler_eccentric_anomaly #(
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ANGLE_WIDTH-1:0] in_mean_anomaly,
  input  logic [15:0]                   in_eccentricity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ANGLE_WIDTH-1:0] out_eccentric_anomaly,
  output logic [3:0]                    out_iterations_used,
  output logic                          out_converged,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_data
);
  import kea_pkg::*;

  localparam int AW = ANGLE_WIDTH;
  localparam int F  = AW - 4;
  localparam logic [63:0] PI_F_U = (PI_Q61 + (64'd1 << (60 - F))) >> (61 - F);
  localparam logic signed [AW:0]   PI_F   = (AW + 1)'(PI_F_U);
  localparam logic signed [AW:0]   TWO_PI = (AW + 1)'(2 * PI_F_U);
  localparam logic signed [AW+1:0] ONE_F  = (AW + 2)'(64'd1 << F);
  localparam logic signed [AW+2:0] SAT_HI = (AW + 3)'((64'd1 << (AW - 1)) - 64'd1);
  localparam logic signed [AW+2:0] SAT_LO = -SAT_HI - (AW + 3)'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_REDUCE, S_SC, S_SC_WAIT, S_MUL_S, S_MUL_C,
    S_DIV, S_DIV_WAIT, S_UPD, S_DONE
  } st_t;

  st_t                   st_r;
  logic [3:0]            limit_r;
  logic [27:0]           tol_r;
  logic signed [AW:0]    m_r;
  logic [15:0]           e_r;
  logic signed [AW-1:0]  ea_r;
  logic signed [AW+1:0]  f_r;
  logic signed [AW+16:0] prod_r;
  logic [3:0]            cnt_r;
  logic                  conv_r;
  logic                  out_valid_r;
  logic signed [AW-1:0]  out_ea_r;
  logic [3:0]            out_cnt_r;
  logic                  out_conv_r;

  logic                  sc_done, div_done;
  logic signed [AW-1:0]  sin_v, cos_v;
  logic [AW+1:0]         quot;

  logic signed [AW+16:0] prod_nxt;
  logic signed [AW:0]    ep;
  logic signed [AW+1:0]  f_nxt, d_full;
  logic [AW+1:0]         n_abs;
  logic signed [AW+2:0]  ea_sum;
  logic signed [AW-1:0]  ea_nxt;
  logic [3:0]            limit_eff, cnt_nxt;
  logic                  tol_ok;

  always_comb begin
    // shared multiplier: e times sine, then e times cosine
    prod_nxt  = $signed({1'b0, e_r}) * ((st_r == S_MUL_S) ? sin_v : cos_v);
    ep        = prod_r[AW+16:16];
    f_nxt     = (AW + 2)'(ea_r) - (AW + 2)'(ep) - (AW + 2)'(m_r);
    d_full    = ONE_F - (AW + 2)'(ep);
    n_abs     = f_r[AW+1] ? (AW + 2)'(-f_r) : (AW + 2)'(f_r);
    ea_sum    = f_r[AW+1] ? (AW + 3)'(ea_r) + (AW + 3)'({1'b0, quot})
                          : (AW + 3)'(ea_r) - (AW + 3)'({1'b0, quot});
    if (ea_sum > SAT_HI) ea_nxt = AW'(SAT_HI);
    else if (ea_sum < SAT_LO) ea_nxt = AW'(SAT_LO);
    else ea_nxt = AW'(ea_sum);
    limit_eff = (limit_r == 4'd0) ? 4'd1 : limit_r;
    cnt_nxt   = cnt_r + 4'd1;
    tol_ok    = 64'(n_abs) <= 64'(tol_r);
  end

  kea_cordic #(.ANGLE_WIDTH(AW)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (st_r == S_SC),
    .angle   (ea_r),
    .done    (sc_done),
    .sin_out (sin_v),
    .cos_out (cos_v)
  );

  kea_div #(.ANGLE_WIDTH(AW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == S_DIV),
    .num   (n_abs),
    .den   (d_full[AW-3:0]),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      limit_r     <= 4'd15;
      tol_r       <= 28'd64;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ITER_LIMIT: limit_r <= cfg_data[3:0];
          CFG_TOLERANCE:  tol_r   <= cfg_data[27:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && st_r != S_DONE) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            m_r   <= (AW + 1)'(in_mean_anomaly);
            e_r   <= in_eccentricity;
            cnt_r <= '0;
            st_r  <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          // bring M into [0, 2*pi)
          if (m_r < 0) m_r <= m_r + TWO_PI;
          else if (m_r >= TWO_PI) m_r <= m_r - TWO_PI;
          else begin
            ea_r <= (e_r < ECC_START_LIMIT) ? AW'(m_r) : AW'(PI_F);
            st_r <= S_SC;
          end
        end
        S_SC:      st_r <= S_SC_WAIT;
        S_SC_WAIT: if (sc_done) st_r <= S_MUL_S;
        S_MUL_S: begin
          prod_r <= prod_nxt;
          st_r   <= S_MUL_C;
        end
        S_MUL_C: begin
          f_r    <= f_nxt;
          prod_r <= prod_nxt;
          st_r   <= S_DIV;
        end
        S_DIV:      st_r <= S_DIV_WAIT;
        S_DIV_WAIT: if (div_done) st_r <= S_UPD;
        S_UPD: begin
          ea_r   <= ea_nxt;
          cnt_r  <= cnt_nxt;
          conv_r <= tol_ok;
          if (cnt_nxt >= limit_eff || tol_ok) st_r <= S_DONE;
          else st_r <= S_SC;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_ea_r    <= ea_r;
            out_cnt_r   <= cnt_r;
            out_conv_r  <= conv_r;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready              = (st_r == S_IDLE);
  assign cfg_ready             = 1'b1;
  assign out_valid             = out_valid_r;
  assign out_eccentric_anomaly = out_ea_r;
  assign out_iterations_used   = out_cnt_r;
  assign out_converged         = out_conv_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("solver still ready after taking an item");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_iterations_used != 4'd0)
    else $error("result with no newton update");

  a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sc_done |-> st_r == S_SC_WAIT)
    else $error("cordic finished outside its wait state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the kepler eccentric anomaly newton solver
`timescale 1ns / 1ps
module tb_top;
  import kea_pkg::*;

  localparam int AW = 32;
  localparam int FB = AW - 4;
  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    logic signed [AW-1:0] anomaly;
    logic [3:0]           updates;
    logic                 conv;
  } solution_t;

  // own copy of the q.30 arctangent table
  localparam longint ATAN_TBL [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [AW-1:0] in_mean_anomaly;
  logic [15:0]          in_eccentricity;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [AW-1:0] out_eccentric_anomaly;
  logic [3:0]           out_iterations_used;
  logic                 out_converged;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [31:0]          cfg_data;

  // predictor copy of the two registers
  logic [3:0]  limit_shadow;
  logic [27:0] tol_shadow;

  solution_t solution_q[$];
  int        err_count;
  bit        gaps_on;
  int        hold_request;

  kepler_eccentric_anomaly #(.ANGLE_WIDTH(AW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mean_anomaly(in_mean_anomaly), .in_eccentricity(in_eccentricity),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_eccentric_anomaly(out_eccentric_anomaly),
    .out_iterations_used(out_iterations_used), .out_converged(out_converged),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // cordic sine/cosine of an angle in q4.F, returned in q4.F
  task automatic cordic_sincos(input longint ang, output longint s_out,
                               output longint c_out);
    longint a, x, y, t;
    bit     flip_cos;
    a = ang * 4;                      // q.28 -> q.30
    x = CORDIC_GAIN_Q30;
    y = 0;
    flip_cos = 1'b0;
    if (a > PI_Q30) a -= 2 * PI_Q30;
    if (a > PI_Q30) a -= 2 * PI_Q30;
    if (a < -PI_Q30) a += 2 * PI_Q30;
    if (a < -PI_Q30) a += 2 * PI_Q30;
    // fold into the right half plane, cosine changes sign
    if (a > HALF_PI_Q30) begin
      a = PI_Q30 - a;
      flip_cos = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      a = -PI_Q30 - a;
      flip_cos = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (a >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        a -= ATAN_TBL[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        a += ATAN_TBL[i];
      end
      x = t;
    end
    if (x > ONE_Q30) x = ONE_Q30;
    if (x < -ONE_Q30) x = -ONE_Q30;
    if (y > ONE_Q30) y = ONE_Q30;
    if (y < -ONE_Q30) y = -ONE_Q30;
    if (flip_cos) x = -x;
    s_out = y >>> 2;                  // q.30 -> q.28, floor
    c_out = x >>> 2;
  endtask

  // newton solve of E - e*sin(E) = M for one item
  task automatic solve_kepler(input logic signed [AW-1:0] m_in,
                              input logic [15:0] ecc, output solution_t sol);
    longint unsigned pi_u, n, q, r, d_u;
    longint pi_f, two_pi, m, e, ea, f, s, c, d, hi_lim;
    int     lim, steps;
    bit     finished;
    pi_u = (64'h6487ED5110B4611A + (64'd1 << (60 - FB))) >> (61 - FB);
    pi_f = longint'(pi_u);
    two_pi = 2 * pi_f;
    hi_lim = (longint'(1) << (AW - 1)) - 1;
    m = m_in;
    e = ecc;
    lim = (limit_shadow == 0) ? 1 : int'(limit_shadow);
    steps = 0;
    f = 0;
    finished = 1'b0;
    if (m < 0) m += two_pi;
    if (m < 0) m += two_pi;
    if (m >= two_pi) m -= two_pi;
    // high eccentricity starts from pi
    ea = (ecc < ECC_START_LIMIT) ? m : pi_f;
    while (!finished) begin
      cordic_sincos(ea, s, c);
      f = ea - ((e * s) >>> 16) - m;
      d = (longint'(1) << FB) - ((e * c) >>> 16);
      d_u = longint'(d);
      n = (f < 0) ? -f : f;
      q = n / d_u;
      r = n % d_u;
      if (q >= 32) begin
        // huge step, clipped and then saturated below
        q = 64'd32 << FB;
      end else begin
        for (int k = 0; k < FB; k++) begin
          r = r << 1;
          q = q << 1;
          if (r >= d_u) begin
            r -= d_u;
            q |= 64'd1;
          end
        end
      end
      ea = (f < 0) ? ea + longint'(q) : ea - longint'(q);
      if (ea > hi_lim) ea = hi_lim;
      if (ea < -hi_lim - 1) ea = -hi_lim - 1;
      steps++;
      if (steps >= lim || n <= tol_shadow) finished = 1'b1;
    end
    sol.anomaly = ea[AW-1:0];
    sol.updates = steps[3:0];
    sol.conv = (((f < 0) ? -f : f) <= longint'(tol_shadow));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // offer one item, hold it until the transfer, then predict its result
  task automatic send_item(input logic signed [AW-1:0] m_in, input logic [15:0] ecc);
    int        gap;
    solution_t sol;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mean_anomaly <= m_in;
    in_eccentricity <= ecc;
    do @(posedge clk); while (!in_ready);
    solve_kepler(m_in, ecc, sol);
    solution_q.push_back(sol);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    wait (solution_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // register write, only issued while the solver is idle
  task automatic write_reg(input logic idx, input logic [31:0] val);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ITER_LIMIT) limit_shadow = val[3:0];
    else tol_shadow = val[27:0];
  endtask

  function automatic logic [15:0] rand_ecc();
    case ($urandom_range(0, 3))
      0: rand_ecc = 16'($urandom_range(52000, 65535));   // around the pi start
      1: rand_ecc = 16'($urandom_range(0, 4000));
      default: rand_ecc = 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [AW-1:0] rand_anomaly();
    // mostly in-orbit angles, sometimes anything the format holds
    if ($urandom_range(0, 3) == 0) rand_anomaly = $urandom;
    else rand_anomaly = $urandom_range(0, 32'd1686629713);
  endfunction

  task automatic test_directed();
    logic signed [AW-1:0] m_set [9];
    logic [15:0]          e_set [6];
    m_set = '{32'sh0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd843314857,
              32'sd1686629713, -32'sd1, 32'sd1, -32'sd843314857, 32'sd1686629712};
    e_set = '{16'd0, 16'd65535, 16'd52428, 16'd52429, 16'd32768, 16'd1};
    foreach (m_set[i]) send_item(m_set[i], e_set[i % 6]);
    // high eccentricity near periapsis drives large newton steps; then format extremes
    send_item(32'sd1, 16'd65535);
    send_item(-32'sd2, 16'd65535);
    send_item(32'sh7FFFFFFF, 16'd65535);
    send_item(32'sh80000000, 16'd0);
    send_item(32'sd1686629713, 16'd52429);
  endtask

  // limit and tolerance extremes, including limit zero acting as one
  task automatic test_register_sweep();
    logic [3:0]  lims [4];
    logic [27:0] tols [4];
    lims = '{4'd0, 4'd1, 4'd15, 4'd3};
    tols = '{28'd0, 28'hFFFFFFF, 28'd64, 28'd4096};
    foreach (lims[i]) begin
      write_reg(CFG_ITER_LIMIT, {28'($urandom), lims[i]});
      foreach (tols[j]) begin
        write_reg(CFG_TOLERANCE, {4'($urandom), tols[j]});
        for (int k = 0; k < 4; k++) send_item(rand_anomaly(), rand_ecc());
      end
    end
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      send_item(rand_anomaly(), rand_ecc());
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = 3000;
    for (int i = 0; i < 8; i++) send_item(rand_anomaly(), rand_ecc());
    gaps_on = 1'b1;
  endtask

  // sender waits for every result before the next item
  task automatic test_drain_between();
    for (int i = 0; i < 10; i++) begin
      quiesce();
      send_item(rand_anomaly(), rand_ecc());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mean_anomaly = '0;
    in_eccentricity = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ITER_LIMIT;
    cfg_data = '0;
    limit_shadow = 4'd15;
    tol_shadow = 28'd64;
    err_count = 0;
    gaps_on = 1'b1;
    hold_request = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_sweep();
    // slow setting: zero tolerance, items run fifteen updates unless the residual hits zero
    write_reg(CFG_ITER_LIMIT, 32'd15);
    write_reg(CFG_TOLERANCE, 32'd0);
    test_random(30);
    write_reg(CFG_TOLERANCE, 32'd64);
    test_backpressure();
    test_drain_between();
    write_reg(CFG_ITER_LIMIT, 32'd6);
    write_reg(CFG_TOLERANCE, 32'd1000);
    test_random(150);
    write_reg(CFG_ITER_LIMIT, 32'd15);
    write_reg(CFG_TOLERANCE, 32'd64);
    test_random(290);

    quiesce();
    repeat (200) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver: random stall per result, or one long hold when requested
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = gaps_on ? $urandom_range(0, 10) : 0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    solution_t want;
    if (rst_n && out_valid && out_ready) begin
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected result E=%0d iters=%0d conv=%0d", $time,
                 out_eccentric_anomaly, out_iterations_used, out_converged);
        err_count++;
      end else begin
        want = solution_q.pop_front();
        if (out_eccentric_anomaly !== want.anomaly) begin
          $display("%0t: eccentric_anomaly expected %0d got %0d", $time,
                   want.anomaly, out_eccentric_anomaly);
          err_count++;
        end
        if (out_iterations_used !== want.updates) begin
          $display("%0t: iterations_used expected %0d got %0d", $time,
                   want.updates, out_iterations_used);
          err_count++;
        end
        if (out_converged !== want.conv) begin
          $display("%0t: converged expected %0d got %0d", $time,
                   want.conv, out_converged);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
